FILE: src/cartridge_bank_switch_irq_mapper_defines.svh
// assertion macros shared by the mapper rtl
// expects clk and rst_n in the scope of each use

`ifndef CARTRIDGE_BANK_SWITCH_IRQ_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_SWITCH_IRQ_MAPPER_DEFINES_SVH

// plain property, checked outside reset
`define CBSIM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// overlapped implication, checked outside reset
`define CBSIM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CBSIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cbsim_pkg.sv
// types, address decode codes and reset constants of the cartridge mapper
// no dependencies
`timescale 1ns / 1ps

package cbsim_pkg;

  typedef logic [15:0] addr_t;
  typedef logic [7:0]  byte_t;
  typedef logic [6:0]  cycles_t;
  typedef logic [1:0]  mirror_t;

  localparam int unsigned PRESCALE_CYCLES_DEF = 114;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANKS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_PRESENT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] ROM_BANKS_RESET   = 9'd32;
  localparam logic                  CHR_PRESENT_RESET = 1'b1;
  localparam logic [CFG_DATA_W-1:0] SMALL_PRG_RESET_W = ROM_BANKS_RESET - 9'd2;
  localparam byte_t                 SMALL_PRG_RESET   = SMALL_PRG_RESET_W[7:0];

  // item kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // write decode
  localparam addr_t ADDR_MASK       = 16'hF003;
  localparam addr_t ADDR_PRG_16K    = 16'h8000;
  localparam addr_t ADDR_PRG_8K     = 16'hC000;
  localparam addr_t ADDR_MIRROR     = 16'hB003;
  localparam addr_t ADDR_CHR_D0     = 16'hD000;
  localparam addr_t ADDR_CHR_D1     = 16'hD001;
  localparam addr_t ADDR_CHR_D2     = 16'hD002;
  localparam addr_t ADDR_CHR_D3     = 16'hD003;
  localparam addr_t ADDR_CHR_E0     = 16'hE000;
  localparam addr_t ADDR_CHR_E1     = 16'hE001;
  localparam addr_t ADDR_CHR_E2     = 16'hE002;
  localparam addr_t ADDR_CHR_E3     = 16'hE003;
  localparam addr_t ADDR_IRQ_RELOAD = 16'hF000;
  localparam addr_t ADDR_IRQ_ACK    = 16'hF001;
  localparam addr_t ADDR_IRQ_CTRL   = 16'hF002;

  // mirroring codes and modes
  localparam cycles_t MIR_CODE_MASK_HI = 7'h7F;
  localparam cycles_t MIR_CODE_SH_A    = 7'h08;
  localparam cycles_t MIR_CODE_SH_B    = 7'h2C;
  localparam cycles_t MIR_CODE_VERT    = 7'h20;
  localparam cycles_t MIR_CODE_HORIZ   = 7'h24;
  localparam cycles_t MIR_CODE_SL      = 7'h28;

  localparam mirror_t MIRROR_VERT  = 2'd0;
  localparam mirror_t MIRROR_HORIZ = 2'd1;
  localparam mirror_t MIRROR_SL    = 2'd2;
  localparam mirror_t MIRROR_SH    = 2'd3;

  localparam byte_t COUNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    IRQ_NONE,
    IRQ_TICK,
    IRQ_RELOAD,
    IRQ_ACK,
    IRQ_CTRL
  } irq_op_t;

  typedef struct packed {
    irq_op_t op;
    byte_t   data;
    cycles_t cycles;
  } irq_cmd_t;

endpackage

FILE: src/cbsim_if.sv
// valid/ready channel interfaces for mapper items and results
// depends on cbsim_pkg
`timescale 1ns / 1ps

interface cbsim_in_if import cbsim_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    mode;
  addr_t   address;
  byte_t   data;
  cycles_t cycles;

  modport source (output valid, mode, address, data, cycles, input ready);
  modport sink (input valid, mode, address, data, cycles, output ready);
endinterface

interface cbsim_out_if import cbsim_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    irq_out;
  mirror_t mirror_mode;
  byte_t   prg_bank_16k;
  byte_t   prg_bank_8k;
  byte_t   chr_bank_0;
  byte_t   chr_bank_1;
  byte_t   chr_bank_2;
  byte_t   chr_bank_3;
  byte_t   chr_bank_4;
  byte_t   chr_bank_5;
  byte_t   chr_bank_6;
  byte_t   chr_bank_7;

  modport source (
    output valid, irq_out, mirror_mode, prg_bank_16k, prg_bank_8k,
           chr_bank_0, chr_bank_1, chr_bank_2, chr_bank_3,
           chr_bank_4, chr_bank_5, chr_bank_6, chr_bank_7,
    input  ready
  );
  modport sink (
    input  valid, irq_out, mirror_mode, prg_bank_16k, prg_bank_8k,
           chr_bank_0, chr_bank_1, chr_bank_2, chr_bank_3,
           chr_bank_4, chr_bank_5, chr_bank_6, chr_bank_7,
    output ready
  );
endinterface

FILE: src/cbsim_irq.sv
// interrupt prescaler, up-counter, reload latch and control of the mapper
// depends on cbsim_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "cartridge_bank_switch_irq_mapper_defines.svh"

module cbsim_irq import cbsim_pkg::*; #(
  parameter int unsigned PRESCALE_CYCLES = PRESCALE_CYCLES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  irq_cmd_t cmd,
  output logic     irq_level_nxt
);

  localparam byte_t      PRE8 = 8'(PRESCALE_CYCLES);
  localparam logic [8:0] PRE9 = 9'(PRESCALE_CYCLES);

  byte_t      reload_r, reload_nxt;
  byte_t      count_r, count_nxt;
  byte_t      prescale_r, prescale_nxt;
  logic [1:0] ctrl_r, ctrl_nxt;
  logic       level_r, level_nxt;

  always_comb begin
    byte_t      cyc;
    logic [8:0] acc;
    reload_nxt   = reload_r;
    count_nxt    = count_r;
    prescale_nxt = prescale_r;
    ctrl_nxt     = ctrl_r;
    level_nxt    = level_r;
    cyc          = ({1'b0, cmd.cycles} > PRE8) ? PRE8 : {1'b0, cmd.cycles};
    acc          = {1'b0, prescale_r} + {1'b0, cyc};
    unique case (cmd.op)
      IRQ_TICK: begin
        if (ctrl_r[1]) begin
          if (acc >= PRE9) begin
            acc = acc - PRE9;
            if (count_r == COUNT_MAX) begin
              count_nxt = reload_r;
              level_nxt = 1'b1;
            end else begin
              count_nxt = count_r + 8'd1;
            end
          end
          prescale_nxt = acc[7:0];
        end
      end
      IRQ_RELOAD: reload_nxt = cmd.data;
      IRQ_ACK: begin
        ctrl_nxt  = ctrl_r[0] ? 2'b11 : 2'b00;
        level_nxt = 1'b0;
      end
      IRQ_CTRL: begin
        ctrl_nxt = cmd.data[1:0];
        if (cmd.data[1]) begin
          count_nxt    = reload_r;
          prescale_nxt = '0;
        end
        level_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r   <= '0;
      count_r    <= '0;
      prescale_r <= '0;
      ctrl_r     <= '0;
      level_r    <= 1'b0;
    end else begin
      reload_r   <= reload_nxt;
      count_r    <= count_nxt;
      prescale_r <= prescale_nxt;
      ctrl_r     <= ctrl_nxt;
      level_r    <= level_nxt;
    end
  end

  assign irq_level_nxt = level_nxt;

  `CBSIM_ASSERT(a_prescale_below_period, prescale_r < PRE8, "prescaler reached its period")
  `CBSIM_ASSERT_IMP(a_rise_reloads, $rose(level_r), count_r == reload_r, "irq raised without reload")
  `CBSIM_ASSERT_NEXT(a_ack_clears, cmd.op == IRQ_ACK, !level_r, "acknowledge left irq set")

endmodule

FILE: src/cartridge_bank_switch_irq_mapper.sv
// top level of the cartridge bank-switch mapper with cycle-driven interrupt
// depends on cbsim_pkg, cbsim_if, cbsim_irq and the assertion macro header
//
//   channel  dir  handshake     beat
//   in_ch    in   valid/ready   mode, address, data, cycles
//   out_ch   out  valid/ready   irq_out, mirror_mode, prg banks, chr_bank_0..7
//   cfg_*    in   write enable  cfg_index, cfg_data
//
// one beat accepted per clock unless the output stalls; its result reaches out_ch
// through the input register, then the result register; state is updated in the same pass
// rst_n is synchronous: banks, mirroring and interrupt state take their reset values
// a stalled result holds in the result register while one more beat waits in the
// input register; in_ch.ready falls only when both are full and out_ch.ready is low
`timescale 1ns / 1ps
`include "cartridge_bank_switch_irq_mapper_defines.svh"

module cartridge_bank_switch_irq_mapper import cbsim_pkg::*; #(
  parameter int unsigned PRESCALE_CYCLES = PRESCALE_CYCLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cbsim_in_if.sink              in_ch,
  cbsim_out_if.source           out_ch
);

  // input register
  logic    s1_valid_r;
  logic    s1_mode_r;
  addr_t   s1_addr_r;
  byte_t   s1_data_r;
  cycles_t s1_cycles_r;

  // bank state
  byte_t   big_prg_r, big_prg_nxt;
  byte_t   small_prg_r, small_prg_nxt;
  byte_t   chr_r [8];
  byte_t   chr_nxt [8];
  mirror_t mirror_r, mirror_nxt;

  // result register
  logic    out_valid_r;
  logic    out_irq_r;
  mirror_t out_mirror_r;
  byte_t   out_big_r;
  byte_t   out_small_r;
  byte_t   out_chr_r [8];

  logic       out_load;
  logic       s1_adv;
  logic       in_acc;
  irq_cmd_t   irq_cmd;
  logic       irq_level_nxt;
  cycles_t    mir_code;
  logic [CFG_DATA_W-1:0] cfg_fixed;

  assign out_load    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_load;
  assign in_ch.ready = !s1_valid_r || out_load;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign mir_code    = s1_data_r[6:0] & MIR_CODE_MASK_HI;
  assign cfg_fixed   = cfg_data - 9'd2;

  always_comb begin
    big_prg_nxt    = big_prg_r;
    small_prg_nxt  = small_prg_r;
    chr_nxt        = chr_r;
    mirror_nxt     = mirror_r;
    irq_cmd.op     = IRQ_NONE;
    irq_cmd.data   = s1_data_r;
    irq_cmd.cycles = s1_cycles_r;
    if (s1_adv) begin
      if (s1_mode_r == MODE_TICK) begin
        irq_cmd.op = IRQ_TICK;
      end else begin
        unique case (s1_addr_r & ADDR_MASK)
          ADDR_PRG_16K:    big_prg_nxt = s1_data_r;
          ADDR_PRG_8K:     small_prg_nxt = s1_data_r;
          ADDR_CHR_D0:     chr_nxt[0] = s1_data_r;
          ADDR_CHR_D1:     chr_nxt[2] = s1_data_r;
          ADDR_CHR_D2:     chr_nxt[1] = s1_data_r;
          ADDR_CHR_D3:     chr_nxt[3] = s1_data_r;
          ADDR_CHR_E0:     chr_nxt[4] = s1_data_r;
          ADDR_CHR_E1:     chr_nxt[6] = s1_data_r;
          ADDR_CHR_E2:     chr_nxt[5] = s1_data_r;
          ADDR_CHR_E3:     chr_nxt[7] = s1_data_r;
          ADDR_MIRROR: begin
            unique case (mir_code) inside
              MIR_CODE_SH_A, MIR_CODE_SH_B: mirror_nxt = MIRROR_SH;
              MIR_CODE_VERT:                mirror_nxt = MIRROR_VERT;
              MIR_CODE_HORIZ:               mirror_nxt = MIRROR_HORIZ;
              MIR_CODE_SL:                  mirror_nxt = MIRROR_SL;
              default:                      mirror_nxt = mirror_r;
            endcase
          end
          ADDR_IRQ_RELOAD: irq_cmd.op = IRQ_RELOAD;
          ADDR_IRQ_ACK:    irq_cmd.op = IRQ_ACK;
          ADDR_IRQ_CTRL:   irq_cmd.op = IRQ_CTRL;
          default:         irq_cmd.op = IRQ_NONE;
        endcase
      end
    end
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROM_BANKS:   small_prg_nxt = cfg_fixed[7:0];
        CFG_CHR_PRESENT: begin
          for (int i = 0; i < 8; i++) begin
            chr_nxt[i] = cfg_data[0] ? 8'(i) : 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  cbsim_irq #(
    .PRESCALE_CYCLES (PRESCALE_CYCLES)
  ) u_irq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (irq_cmd),
    .irq_level_nxt (irq_level_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      big_prg_r   <= '0;
      small_prg_r <= SMALL_PRG_RESET;
      mirror_r    <= MIRROR_VERT;
      for (int i = 0; i < 8; i++) begin
        chr_r[i] <= CHR_PRESENT_RESET ? 8'(i) : 8'd0;
      end
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      big_prg_r   <= big_prg_nxt;
      small_prg_r <= small_prg_nxt;
      chr_r       <= chr_nxt;
      mirror_r    <= mirror_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r   <= in_ch.mode;
      s1_addr_r   <= in_ch.address;
      s1_data_r   <= in_ch.data;
      s1_cycles_r <= in_ch.cycles;
    end
    if (s1_adv) begin
      out_irq_r    <= irq_level_nxt;
      out_mirror_r <= mirror_nxt;
      out_big_r    <= big_prg_nxt;
      out_small_r  <= small_prg_nxt;
      out_chr_r    <= chr_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.irq_out      = out_irq_r;
  assign out_ch.mirror_mode  = out_mirror_r;
  assign out_ch.prg_bank_16k = out_big_r;
  assign out_ch.prg_bank_8k  = out_small_r;
  assign out_ch.chr_bank_0   = out_chr_r[0];
  assign out_ch.chr_bank_1   = out_chr_r[1];
  assign out_ch.chr_bank_2   = out_chr_r[2];
  assign out_ch.chr_bank_3   = out_chr_r[3];
  assign out_ch.chr_bank_4   = out_chr_r[4];
  assign out_ch.chr_bank_5   = out_chr_r[5];
  assign out_ch.chr_bank_6   = out_chr_r[6];
  assign out_ch.chr_bank_7   = out_chr_r[7];

  `CBSIM_ASSERT_NEXT(a_adv_gives_result, s1_adv, out_ch.valid, "advanced beat gave no result")
  `CBSIM_ASSERT_IMP(a_ready_when_empty, !out_ch.valid, in_ch.ready, "ready low with empty output")
  `CBSIM_ASSERT_IMP(a_irq_rise_on_tick, $rose(out_irq_r), $past(s1_adv) && $past(s1_mode_r == MODE_TICK), "irq rose without a tick")

endmodule
